// File: rtl/core/incremental_pid_clamped_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the incremental PID block
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_CLAMPED_ASSERT_SVH
`define INCREMENTAL_PID_CLAMPED_ASSERT_SVH

// Same-cycle implication, reported by $error.
`define IPIDC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reported by $error.
`define IPIDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ipidc_pkg.sv
// ---------------------------------------------------------------------------
// Incremental PID package
// Register indexes, fixed field widths and the configuration bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package ipidc_pkg;

   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_OUT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INT_LIMIT = 3'd4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7fff;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic [LIMIT_W-1:0]       max_output;
      logic [LIMIT_W-1:0]       integral_limit;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/core/incremental_pid_clamped.sv
// ---------------------------------------------------------------------------
// Incremental PID controller with integral clamp and output saturation
//
// Each transfer on the req channel carries a setpoint and a measurement;
// one transfer on the rsp channel returns the saturated drive for it.
// req_tdata: setpoint in the low DATA_WIDTH bits, measurement above it.
// rsp_tdata: drive in the low DATA_WIDTH bits, padding bits zero.
// Gains and bounds are written over the csr channel, index 0 to 4 for
// gain_p, gain_i, gain_d, max_output and integral_limit; csr_ready is
// always high, writes to other indexes are dropped.
// Throughput: one item per cycle while rsp_tready is high, set by the
// single registered pass through the three gain multipliers and the
// accumulator clamp; a sample waits in the input register before it.
// An input register and a result register part the two channels, so a
// new item is taken while a finished result waits. When rsp_tready is
// low the result holds, one more item waits in the input register, and
// req_tready then drops.
// Reset clears both registers, the error history and the accumulator,
// sets the gains to zero and the bounds to their maximum.
// ---------------------------------------------------------------------------
`default_nettype none

module incremental_pid_clamped #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8,
   localparam int REQ_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [REQ_TDATA_W-1:0]           req_tdata,  // setpoint, measurement
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [RSP_TDATA_W-1:0]                rsp_tdata,  // drive
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ipidc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [ipidc_pkg::CSR_DATA_W-1:0] csr_data
);

   ipidc_pkg::cfg_type cfg;

   logic                  in_valid_ff;
   logic [DATA_WIDTH-1:0] setpoint_ff;
   logic [DATA_WIDTH-1:0] measurement_ff;
   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] drive_ff;
   logic signed [DATA_WIDTH-1:0] drive_in;
   logic                  advance;

   // Advance when the result register is free or being drained.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      rsp_tdata                 = '0;
      rsp_tdata[DATA_WIDTH-1:0] = drive_ff;
   end

   ipidc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipidc_core #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .setpoint    (setpoint_ff),
      .measurement (measurement_ff),
      .cfg         (cfg),
      .drive_in    (drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         setpoint_ff    <= req_tdata[DATA_WIDTH-1:0];
         measurement_ff <= req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
      end
      if (advance) begin
         drive_ff <= drive_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ipidc_csr.sv
// ---------------------------------------------------------------------------
// Incremental PID configuration registers
// Gains and bounds, written one transfer at a time over the csr channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ipidc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ipidc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [ipidc_pkg::CSR_DATA_W-1:0] csr_data,
   output ipidc_pkg::cfg_type                    cfg
);

   ipidc_pkg::cfg_type cfg_ff;
   ipidc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ipidc_pkg::CSR_GAIN_P:    cfg_in.gain_p = csr_data;
            ipidc_pkg::CSR_GAIN_I:    cfg_in.gain_i = csr_data;
            ipidc_pkg::CSR_GAIN_D:    cfg_in.gain_d = csr_data;
            ipidc_pkg::CSR_MAX_OUT:   cfg_in.max_output = csr_data[ipidc_pkg::LIMIT_W-1:0];
            ipidc_pkg::CSR_INT_LIMIT: cfg_in.integral_limit =
                                         csr_data[ipidc_pkg::LIMIT_W-1:0];
            default:                  cfg_in = cfg_ff; // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.max_output     <= ipidc_pkg::LIMIT_RESET;
         cfg_ff.integral_limit <= ipidc_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ipidc_core.sv
// ---------------------------------------------------------------------------
// Incremental PID datapath
// Error history, the three gain products, integral clamp and the saturated
// drive accumulator; produces the next drive value in one pass.
// ---------------------------------------------------------------------------
`default_nettype none

module ipidc_core #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [DATA_WIDTH-1:0]        setpoint,
   input  wire logic [DATA_WIDTH-1:0]        measurement,
   input  wire ipidc_pkg::cfg_type           cfg,
   output logic signed [DATA_WIDTH-1:0]      drive_in
);

   localparam int ERR_W = DATA_WIDTH + 1;
   localparam int D1_W  = ERR_W + 1;
   localparam int D2_W  = ERR_W + 2;
   localparam int P_W   = ipidc_pkg::GAIN_W + D1_W;
   localparam int I_W   = ipidc_pkg::GAIN_W + ERR_W;
   localparam int D_W   = ipidc_pkg::GAIN_W + D2_W;
   localparam int ACC_W = ipidc_pkg::LIMIT_W + FRAC_BITS + 2;
   localparam int SUM_A = D_W + 2;
   localparam int SUM_B = ipidc_pkg::LIMIT_W + FRAC_BITS + 3;
   localparam int SUM_W = (SUM_A > SUM_B) ? SUM_A : SUM_B;

   logic signed [ERR_W-1:0] e1_ff;
   logic signed [ERR_W-1:0] e2_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   logic signed [ERR_W-1:0] err;
   logic signed [D1_W-1:0]  diff1;
   logic signed [D2_W-1:0]  diff2;
   logic signed [ipidc_pkg::GAIN_W-1:0] gain_p;
   logic signed [ipidc_pkg::GAIN_W-1:0] gain_i;
   logic signed [ipidc_pkg::GAIN_W-1:0] gain_d;
   logic signed [P_W-1:0]   p_term;
   logic signed [I_W-1:0]   i_raw;
   logic signed [D_W-1:0]   d_term;
   logic signed [SUM_W-1:0] i_ext;
   logic signed [SUM_W-1:0] i_clamped;
   logic signed [SUM_W-1:0] i_bound;
   logic signed [SUM_W-1:0] out_bound;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] sum_clamped;
   logic signed [ACC_W-1:0] acc_shifted;

   assign gain_p = cfg.gain_p;
   assign gain_i = cfg.gain_i;
   assign gain_d = cfg.gain_d;

   // Errors and differences are kept exact by growing one bit per step.
   assign err   = {setpoint[DATA_WIDTH-1], setpoint} - {measurement[DATA_WIDTH-1], measurement};
   assign diff1 = {err[ERR_W-1], err} - {e1_ff[ERR_W-1], e1_ff};
   assign diff2 = {{2{err[ERR_W-1]}}, err} - {e1_ff[ERR_W-1], e1_ff, 1'b0}
                + {{2{e2_ff[ERR_W-1]}}, e2_ff};

   assign p_term = gain_p * diff1;
   assign i_raw  = gain_i * err;
   assign d_term = gain_d * diff2;

   assign i_bound   = $signed(SUM_W'({cfg.integral_limit, {FRAC_BITS{1'b0}}}));
   assign out_bound = $signed(SUM_W'({cfg.max_output, {FRAC_BITS{1'b0}}}));
   assign i_ext     = SUM_W'(i_raw);

   always_comb begin
      priority if (i_ext > i_bound) begin
         i_clamped = i_bound;
      end else if (i_ext < -i_bound) begin
         i_clamped = -i_bound;
      end else begin
         i_clamped = i_ext;
      end
   end

   assign sum = SUM_W'(acc_ff) + SUM_W'(p_term) + i_clamped + SUM_W'(d_term);

   always_comb begin
      priority if (sum > out_bound) begin
         sum_clamped = out_bound;
      end else if (sum < -out_bound) begin
         sum_clamped = -out_bound;
      end else begin
         sum_clamped = sum;
      end
   end

   assign acc_in      = ACC_W'(sum_clamped);
   assign acc_shifted = acc_in >>> FRAC_BITS;
   assign drive_in    = DATA_WIDTH'(acc_shifted);

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff  <= '0;
         e2_ff  <= '0;
         acc_ff <= '0;
      end else if (advance) begin
         e1_ff  <= err;
         e2_ff  <= e1_ff;
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ipidc_checker.sv
// ---------------------------------------------------------------------------
// Incremental PID port checker
// Watches the req and rsp channels of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "incremental_pid_clamped_assert.svh"

module ipidc_checker #(
   parameter int DATA_WIDTH = 16,
   localparam int RSP_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result holds its value.
   `IPIDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "rsp result dropped or changed while stalled")

   // Input backpressure only when both registers are full and the rsp side stalls.
   `IPIDC_ASSERT_NOW(a_req_ready, clock, reset, !req_tready,
      rsp_tvalid && !rsp_tready, "req_tready low without a stalled result")

   // A fresh result always follows a req transfer held in the input register.
   `IPIDC_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_tvalid),
      $past(req_tvalid && req_tready, 2), "rsp_tvalid rose without a req transfer")

   // Nothing is presented straight after reset.
   `IPIDC_ASSERT_NOW(a_reset_idle, clock, 1'b0, $past(reset),
      !rsp_tvalid, "rsp_tvalid high after reset")

endmodule

bind incremental_pid_clamped ipidc_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_ipidc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: bench/incremental_pid_clamped_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Incremental PID checker
// Watches the csr, req and rsp channels. Keeps its own copy of the gains,
// the error history and the drive accumulator, predicts the drive for each
// req transfer and compares every rsp transfer with the oldest prediction.
// ---------------------------------------------------------------------------

module incremental_pid_clamped_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [31:0]                      req_tdata,  // setpoint, measurement
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [15:0]                      rsp_tdata,  // drive
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ipidc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [ipidc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               mismatches,
   output int                               pending,
   output int                               checked
);

   import ipidc_pkg::*;

   localparam int FRAC = 8;

   logic signed [15:0]  gain_prop;
   logic signed [15:0]  gain_int;
   logic signed [15:0]  gain_der;
   logic [14:0]         drive_bound;
   logic [14:0]         int_bound;
   logic signed [16:0]  err_prev;
   logic signed [16:0]  err_older;
   logic signed [24:0]  drive_acc;
   logic signed [15:0]  drive_queue[$];
   logic signed [15:0]  expected_drive;

   initial begin
      mismatches = 0;
      pending    = 0;
      checked    = 0;
   end

   function automatic longint clamp_sym(input longint v, input longint bound);
      if (v > bound) return bound;
      if (v < -bound) return -bound;
      return v;
   endfunction

   // Advance the loop state by one sample and return the new drive.
   function automatic logic signed [15:0] advance_loop(input logic signed [15:0] setpoint,
                                                       input logic signed [15:0] measurement);
      longint err;
      longint p_term;
      longint i_term;
      longint d_term;
      longint acc;
      err    = longint'(setpoint) - longint'(measurement);
      p_term = longint'(gain_prop) * (err - longint'(err_prev));
      i_term = clamp_sym(longint'(gain_int) * err, longint'(int_bound) << FRAC);
      d_term = longint'(gain_der) *
               (err - 2 * longint'(err_prev) + longint'(err_older));
      acc    = clamp_sym(longint'(drive_acc) + p_term + i_term + d_term,
                         longint'(drive_bound) << FRAC);
      drive_acc = 25'(acc);
      err_older = err_prev;
      err_prev  = 17'(err);
      return 16'(acc >>> FRAC);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gain_prop   = '0;
         gain_int    = '0;
         gain_der    = '0;
         drive_bound = LIMIT_RESET;
         int_bound   = LIMIT_RESET;
         err_prev    = '0;
         err_older   = '0;
         drive_acc   = '0;
         drive_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_P:    gain_prop   = csr_data;
               CSR_GAIN_I:    gain_int    = csr_data;
               CSR_GAIN_D:    gain_der    = csr_data;
               CSR_MAX_OUT:   drive_bound = csr_data[LIMIT_W-1:0];
               CSR_INT_LIMIT: int_bound   = csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            drive_queue.push_back(advance_loop(req_tdata[15:0], req_tdata[31:16]));
         if (rsp_tvalid && rsp_tready) begin
            if (drive_queue.size() == 0) begin
               mismatches++;
               $display("%0t: drive transfer with nothing outstanding: expected none, actual %0d",
                        $time, $signed(rsp_tdata));
            end else begin
               expected_drive = drive_queue.pop_front();
               checked++;
               if (rsp_tdata !== expected_drive) begin
                  mismatches++;
                  $display("%0t: drive wrong: expected %0d, actual %0d",
                           $time, expected_drive, $signed(rsp_tdata));
               end
            end
         end
      end
      pending = drive_queue.size();
   end

endmodule

// File: bench/incremental_pid_clamped_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Incremental PID testbench
// Drives setpoint/measurement pairs and gain/bound writes into the block,
// first a directed set of extremes and bound cases, then random samples
// under many random settings, most with sender gaps and receiver stalls.
// ---------------------------------------------------------------------------

module incremental_pid_clamped_tb;

   import ipidc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_LAST_INDEX = '1;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 166;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int mismatches;
   int pending;
   int checked;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int samples_sent   = 0;
   int settings_used  = 0;
   logic [15:0] sp;
   logic [15:0] ms;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   incremental_pid_clamped dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   incremental_pid_clamped_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3: return 16'($urandom_range(0, 600)) - 16'd300;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_bound();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'($urandom_range(0, 400));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [15:0] setpoint, input logic [15:0] measurement);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {measurement, setpoint};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // Hold the req channel idle until every predicted drive has arrived.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Write all five registers; a spare index sits among them and must be dropped.
   task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] out_bound,
                             input logic [15:0] int_bound);
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_LAST_INDEX - CSR_ADDR_W'($urandom_range(0, 2)), 16'($urandom));
      write_reg(CSR_GAIN_D, kd);
      write_reg(CSR_MAX_OUT, out_bound);
      write_reg(CSR_INT_LIMIT, int_bound);
      settings_used++;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset gains are zero, so the drive stays at zero
      send_sample(16'd100, 16'hffce);
      send_sample(16'h8000, 16'h7fff);
      drain();

      // full-scale error swings; bit 15 of the bound write must be ignored
      load_gains(16'h0100, 16'h7fff, 16'h8000, 16'hffff, 16'h7fff);
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff);
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h7fff);
      send_sample(16'h0000, 16'h0000);
      drain();

      // zero drive bound forces zero out
      load_gains(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff);
      send_sample(16'h1234, 16'hedcc);
      drain();

      // zero integral bound removes the integral term
      load_gains(16'h7fff, 16'h0080, 16'h0000, 16'h7fff, 16'h0000);
      send_sample(16'h0001, 16'h0000);
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff);
      send_sample(16'h0000, 16'h0001);
      drain();

      // small bounds, fractional gains
      load_gains(16'h0040, 16'h0100, 16'h0020, 16'd100, 16'd5);
      send_sample(16'd10, 16'd0);
      send_sample(16'd10, 16'd3);
      send_sample(16'hfff6, 16'd20);
      send_sample(16'd0, 16'd0);
      send_sample(16'd500, 16'hfe0c);
      send_sample(16'd7, 16'd7);
      drain();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < SEGMENTS / 3) begin
            send_idle_pct  = 8;
            recv_stall_pct = 74;
         end else if (seg < 2 * SEGMENTS / 3) begin
            send_idle_pct  = 74;
            recv_stall_pct = 8;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         load_gains(pick_value(), pick_value(), pick_value(), pick_bound(), pick_bound());
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // stop feeding midway until the block has caught up
            if (n == SEGMENT_ITEMS / 2)
               drain();
            sp = pick_value();
            if ($urandom_range(0, 1))
               ms = sp + 16'($urandom_range(0, 64)) - 16'd32;
            else
               ms = pick_value();
            send_sample(sp, ms);
         end
         drain();
      end

      repeat (4) @(posedge clock);
      $display("Run covered %0d samples over %0d gain and bound settings,",
               samples_sent, settings_used);
      $display("%0d drive results compared under sender gaps and receiver stalls.", checked);
      if (mismatches == 0)
         $display("incremental_pid_clamped: match");
      else
         $display("incremental_pid_clamped: mismatch");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d drive results outstanding.", pending);
      $display("incremental_pid_clamped: mismatch");
      $finish;
   end

endmodule
